FILE: rtl/zbr_pkg.sv
`default_nettype none
package zbr_pkg;

  localparam int ScreenWidth  = 256;
  localparam int ScreenHeight = 256;
  localparam int XW = $clog2(ScreenWidth);
  localparam int YW = $clog2(ScreenHeight);
  localparam int AW = XW + YW;
  localparam int PixTotal = ScreenWidth * ScreenHeight;

  localparam logic signed [15:0] DepthMin = 16'sh8000;
  localparam logic signed [15:0] DepthMax = 16'sh7fff;
  localparam logic [16:0] CountMax = 17'h1ffff;

  localparam logic OpDraw = 1'b0;
  localparam logic OpRead = 1'b1;

  // Width of the edge and area terms: 13-bit differences, product plus one.
  localparam int EW = 27;
  // Width of the depth numerator: edge term times 17-bit difference, sum of two.
  localparam int NW = 45;
  // Divider quotient width; the quotient never exceeds the numerator in size.
  localparam int QW = NW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_MUL, ST_ADD, ST_DIV, ST_SAT,
    ST_RMW, ST_NEXT, ST_RDWAIT, ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/zbr_divider.sv
`default_nettype none
module zbr_divider
  import zbr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [EW-1:0] den,
  output logic                      done,
  output logic signed [NW-1:0]      quot
);

  // Restoring division on magnitudes, one quotient bit a cycle.
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0]  rem_r, rem_nxt;
  logic [NW-1:0]  q_r, q_nxt;
  logic [EW-1:0]  den_r;
  logic           neg_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [NW-1:0]  num_mag;
  logic [NW:0]    trial;
  logic [NW:0]    shifted;

  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, q_r[NW-1]};
    trial    = shifted - {{(NW+1-EW){1'b0}}, den_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num_mag;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[NW]) begin
        rem_nxt = trial[NW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[NW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done   <= busy_r && (cnt_r == CW'(1));
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[NW-1];
    end
  end

  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule
`default_nettype wire

FILE: rtl/zbuffer_triangle_rasterizer.sv
// Read word: the read is registered, copied out in ST_RDWAIT and offered in ST_OUT.
// Draw word: a setup state, then per pixel of the clipped box ST_MUL; a pixel that is
// outside the triangle goes on through ST_NEXT, a covered one through ST_ADD, ST_DIV
// (the bit-serial depth divider, 45 quotient bits, one a cycle), ST_SAT and ST_RMW.
// One word is in flight at a time. After reset the depth and colour memories are
// cleared one entry a cycle, all 65536 entries, during which no word is accepted.
`default_nettype none
module zbuffer_triangle_rasterizer
  import zbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic signed [11:0] in_v0_x,
  input  wire logic signed [11:0] in_v0_y,
  input  wire logic signed [15:0] in_v0_z,
  input  wire logic signed [11:0] in_v1_x,
  input  wire logic signed [11:0] in_v1_y,
  input  wire logic signed [15:0] in_v1_z,
  input  wire logic signed [11:0] in_v2_x,
  input  wire logic signed [11:0] in_v2_y,
  input  wire logic signed [15:0] in_v2_z,
  input  wire logic        [31:0] in_fill_color,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [16:0] out_pixels_written,
  output logic                    out_degenerate,
  output logic             [31:0] out_pixel_color,
  output logic signed      [15:0] out_pixel_depth,
  output logic                    out_out_of_range
);

  // Memories.
  logic signed [15:0] depth_mem [PixTotal];
  logic        [31:0] color_mem [PixTotal];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [15:0] mem_wdepth;
  logic [31:0]        mem_wcolor;
  logic signed [15:0] rd_depth;
  logic [31:0]        rd_color;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
      color_mem[mem_waddr] <= mem_wcolor;
    end
    rd_depth <= depth_mem[mem_raddr];
    rd_color <= color_mem[mem_raddr];
  end

  state_t state_r, state_nxt;

  // Item registers.
  logic signed [12:0] x0_r, y0_r, dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [15:0] z0_r;
  logic signed [16:0] dz1_r, dz2_r;
  logic [31:0]        color_r;
  logic signed [EW-1:0] area_r;
  logic [XW-1:0] bx0_r, bx1_r, px_r;
  logic [YW-1:0] by0_r, by1_r, py_r;
  logic          empty_r;
  logic signed [EW-1:0] ux_r, uy_r;
  logic signed [15:0]   z_r;
  logic [16:0]   count_r;
  logic [AW-1:0] clr_r;
  logic          rd_oor_r;

  // Setup: box clip from raw item fields; area from the registered differences.
  logic signed [12:0] sx0, sy0, sx1, sy1, sx2, sy2;
  logic signed [12:0] mnx, mxx, mny, mxy;
  logic signed [EW-1:0] area_c;
  logic empty_c;
  assign sx0 = 13'(in_v0_x);
  assign sy0 = 13'(in_v0_y);
  assign sx1 = 13'(in_v1_x);
  assign sy1 = 13'(in_v1_y);
  assign sx2 = 13'(in_v2_x);
  assign sy2 = 13'(in_v2_y);

  always_comb begin
    mnx = (sx0 < sx1) ? sx0 : sx1; mnx = (mnx < sx2) ? mnx : sx2;
    mxx = (sx0 > sx1) ? sx0 : sx1; mxx = (mxx > sx2) ? mxx : sx2;
    mny = (sy0 < sy1) ? sy0 : sy1; mny = (mny < sy2) ? mny : sy2;
    mxy = (sy0 > sy1) ? sy0 : sy1; mxy = (mxy > sy2) ? mxy : sy2;
    if (mnx < 0) mnx = '0;
    if (mny < 0) mny = '0;
    if (mxx > 13'(ScreenWidth - 1))  mxx = 13'(ScreenWidth - 1);
    if (mxy > 13'(ScreenHeight - 1)) mxy = 13'(ScreenHeight - 1);
    empty_c = (mnx > mxx) || (mny > mxy);
  end

  // Area is formed in the setup cycle from registered differences.
  assign area_c = EW'(dx2_r * dy1_r) - EW'(dx1_r * dy2_r);

  // Edge terms for the current pixel, normalised to a positive area.
  logic signed [12:0] ex, ey;
  logic signed [EW-1:0] ux_c, uy_c, uz_c, w0_c;
  assign ex = x0_r - $signed({1'b0, 12'(px_r)});
  assign ey = y0_r - $signed({1'b0, 12'(py_r)});
  always_comb begin
    ux_c = EW'(dx1_r * ey) - EW'(ex * dy1_r);
    uy_c = EW'(ex * dy2_r) - EW'(dx2_r * ey);
    uz_c = area_r;
    if (area_r < 0) begin
      ux_c = -ux_c;
      uy_c = -uy_c;
      uz_c = -area_r;
    end
    w0_c = uz_c - ux_c - uy_c;
  end

  // Depth numerator from the registered edge terms, taken by the divider at its start.
  logic signed [NW-1:0] num_c;
  assign num_c = NW'(ux_r * dz1_r) + NW'(uy_r * dz2_r);

  logic signed [NW-1:0] zsum;
  logic div_start, div_done;
  logic signed [NW-1:0] quot;
  logic [EW-1:0] area_mag;
  assign area_mag = area_r[EW-1] ? EW'(-area_r) : EW'(area_r);

  zbr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (area_mag),
    .done  (div_done),
    .quot  (quot)
  );

  assign zsum = quot + NW'(z0_r);

  logic last_px;
  assign last_px = (py_r == by1_r) && (px_r == bx1_r);
  logic covered;
  assign covered = !ux_c[EW-1] && !uy_c[EW-1] && !w0_c[EW-1];

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = {py_r, px_r};
    mem_raddr  = {py_r, px_r};
    mem_wdepth = z_r;
    mem_wcolor = color_r;
    div_start  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        mem_wdepth = DepthMin;
        mem_wcolor = '0;
        if (clr_r == AW'(PixTotal - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        mem_raddr = {in_v0_y[YW-1:0], in_v0_x[XW-1:0]};
        if (in_valid) state_nxt = (in_op == OpRead) ? ST_RDWAIT : ST_SETUP;
      end
      ST_SETUP: begin
        if (area_c == '0 || empty_r) state_nxt = ST_OUT;
        else state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (covered) state_nxt = ST_ADD;
        else if (last_px) state_nxt = ST_OUT;
        else state_nxt = ST_NEXT;
      end
      ST_ADD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) state_nxt = ST_SAT;
      ST_SAT: state_nxt = ST_RMW;
      ST_RMW: begin
        if (rd_depth < z_r) mem_we = 1'b1;
        state_nxt = last_px ? ST_OUT : ST_NEXT;
      end
      ST_NEXT: state_nxt = ST_MUL;
      ST_RDWAIT: state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        x0_r    <= sx0;
        y0_r    <= sy0;
        z0_r    <= in_v0_z;
        dx1_r   <= sx1 - sx0;
        dy1_r   <= sy1 - sy0;
        dx2_r   <= sx2 - sx0;
        dy2_r   <= sy2 - sy0;
        dz1_r   <= 17'(in_v1_z) - 17'(in_v0_z);
        dz2_r   <= 17'(in_v2_z) - 17'(in_v0_z);
        color_r <= in_fill_color;
        bx0_r   <= mnx[XW-1:0];
        bx1_r   <= mxx[XW-1:0];
        by0_r   <= mny[YW-1:0];
        by1_r   <= mxy[YW-1:0];
        px_r    <= mnx[XW-1:0];
        py_r    <= mny[YW-1:0];
        empty_r <= empty_c;
        count_r <= '0;
        rd_oor_r <= (in_v0_x < 0) || (in_v0_x >= 12'(ScreenWidth)) ||
                    (in_v0_y < 0) || (in_v0_y >= 12'(ScreenHeight));
        out_pixels_written <= '0;
        out_degenerate     <= 1'b0;
        out_out_of_range   <= 1'b0;
        out_pixel_color    <= '0;
        out_pixel_depth    <= DepthMin;
      end
      ST_SETUP: begin
        area_r <= area_c;
        if (area_c == '0) out_degenerate <= 1'b1;
      end
      ST_MUL: begin
        ux_r <= ux_c;
        uy_r <= uy_c;
      end
      ST_SAT: begin
        if (zsum < NW'(DepthMin)) z_r <= DepthMin;
        else if (zsum > NW'(DepthMax)) z_r <= DepthMax;
        else z_r <= zsum[15:0];
      end
      ST_RMW: begin
        if (rd_depth < z_r && count_r != CountMax) count_r <= count_r + 1'b1;
        if (last_px) out_pixels_written <=
          (rd_depth < z_r && count_r != CountMax) ? count_r + 1'b1 : count_r;
      end
      ST_NEXT: begin
        if (py_r == by1_r) begin
          py_r <= by0_r;
          px_r <= px_r + 1'b1;
        end else begin
          py_r <= py_r + 1'b1;
        end
      end
      ST_RDWAIT: begin
        out_out_of_range <= rd_oor_r;
        if (!rd_oor_r) begin
          out_pixel_color <= rd_color;
          out_pixel_depth <= rd_depth;
        end
      end
      default: ;
    endcase
    if (state_r == ST_MUL && !covered && last_px) out_pixels_written <= count_r;
  end

endmodule
`default_nettype wire
